[src/rnhc_pkg.sv]
package rnhc_pkg;

   localparam int ENTRIES = 16;
   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   localparam logic [31:0] TTL_RESET = 32'd60000;

   localparam logic [1:0] OP_RECORD = 2'd0;
   localparam logic [1:0] OP_LOOKUP = 2'd1;
   localparam logic [1:0] OP_PRUNE  = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [63:0] key_hi;
      logic [63:0] key_lo;
      logic [47:0] hop_mac;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [47:0] next_hop;
   } rsp_type;

   typedef struct packed {
      logic [63:0] key_hi;
      logic [63:0] key_lo;
      logic [47:0] mac;
      logic [31:0] stamp;
   } entry_type;

   // write port of the entry store
   typedef struct packed {
      logic             wr_en;
      logic             clr_en;
      logic [IDX_W-1:0] idx;
      entry_type        entry;
   } store_cmd_type;

   // flags from the shared compare unit
   typedef struct packed {
      logic key_eq;
      logic ref_lt;
      logic over_ttl;
   } cmp_type;

endpackage

[src/rnhc_store.sv]
module rnhc_store (
   input  logic                             clock,
   input  logic                             reset,
   input  rnhc_pkg::store_cmd_type          cmd,
   input  logic [rnhc_pkg::IDX_W-1:0]       rd_addr,
   output rnhc_pkg::entry_type              rd_entry,
   output logic [rnhc_pkg::ENTRIES-1:0]     valid
);

   rnhc_pkg::entry_type mem_ff [rnhc_pkg::ENTRIES];
   rnhc_pkg::entry_type rd_entry_ff;
   logic [rnhc_pkg::ENTRIES-1:0] valid_ff;
   logic [rnhc_pkg::ENTRIES-1:0] valid_in;

   always_comb begin
      valid_in = valid_ff;
      if (cmd.wr_en) begin
         valid_in[cmd.idx] = 1'b1;
      end
      if (cmd.clr_en) begin
         valid_in[cmd.idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[cmd.idx] <= cmd.entry;
      end
      rd_entry_ff <= mem_ff[rd_addr];
   end

   assign rd_entry = rd_entry_ff;
   assign valid    = valid_ff;

endmodule

[src/rnhc_unit.sv]
module rnhc_unit (
   input  rnhc_pkg::entry_type entry,
   input  rnhc_pkg::req_type   req,
   input  logic [31:0]         oldest,
   input  logic [31:0]         ttl,
   output rnhc_pkg::cmp_type   cmp
);

   logic [31:0] lhs;
   logic [31:0] rhs;
   logic [31:0] age;

   // record: entry older than best so far; prune: negative age
   always_comb begin
      if (req.op == rnhc_pkg::OP_PRUNE) begin
         lhs = req.now_ms;
         rhs = entry.stamp;
      end else begin
         lhs = entry.stamp;
         rhs = oldest;
      end
   end

   assign age          = req.now_ms - entry.stamp;
   assign cmp.ref_lt   = (lhs < rhs);
   assign cmp.over_ttl = (age > ttl);
   assign cmp.key_eq   = (entry.key_hi == req.key_hi) && (entry.key_lo == req.key_lo);

endmodule

[src/rnhc_ctrl.sv]
module rnhc_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  rnhc_pkg::req_type                req_data,
   output logic                             req_stall,
   input  logic                             rsp_free,
   input  logic [rnhc_pkg::ENTRIES-1:0]     valid,
   input  rnhc_pkg::entry_type              rd_entry,
   input  rnhc_pkg::cmp_type                cmp,
   output rnhc_pkg::req_type                cur_req,
   output logic [31:0]                      oldest,
   output logic [rnhc_pkg::IDX_W-1:0]       rd_addr,
   output rnhc_pkg::store_cmd_type          cmd,
   output logic                             done,
   output rnhc_pkg::rsp_type                res
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_LOAD  = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_WRITE = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   localparam logic [rnhc_pkg::IDX_W-1:0] LAST = rnhc_pkg::IDX_W'(rnhc_pkg::ENTRIES - 1);

   logic [2:0]                   state_ff, state_in;
   logic [rnhc_pkg::IDX_W-1:0]   cnt_ff, cnt_in;
   rnhc_pkg::req_type            req_ff, req_in;
   logic                         hit_ff, hit_in;
   logic [rnhc_pkg::IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   logic [47:0]                  hop_ff, hop_in;
   logic                         free_ff, free_in;
   logic [rnhc_pkg::IDX_W-1:0]   free_idx_ff, free_idx_in;
   logic                         old_have_ff, old_have_in;
   logic [31:0]                  old_time_ff, old_time_in;
   logic [rnhc_pkg::IDX_W-1:0]   old_idx_ff, old_idx_in;
   logic                         cur_valid;
   logic                         keyed;

   assign cur_valid = valid[cnt_ff];
   assign keyed     = (req_ff.op == rnhc_pkg::OP_RECORD) || (req_ff.op == rnhc_pkg::OP_LOOKUP);

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      req_in      = req_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hop_in      = hop_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      old_have_in = old_have_ff;
      old_time_in = old_time_ff;
      old_idx_in  = old_idx_ff;
      req_stall   = 1'b1;
      done        = 1'b0;
      cmd         = '0;
      cmd.idx     = cnt_ff;
      cmd.entry   = '{key_hi: req_ff.key_hi, key_lo: req_ff.key_lo,
                      mac: req_ff.hop_mac, stamp: req_ff.now_ms};

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               req_in      = req_data;
               cnt_in      = '0;
               hit_in      = 1'b0;
               free_in     = 1'b0;
               old_have_in = 1'b0;
               hop_in      = '0;
               if (req_data.op == rnhc_pkg::OP_RECORD || req_data.op == rnhc_pkg::OP_LOOKUP
                   || req_data.op == rnhc_pkg::OP_PRUNE) begin
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_LOAD: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (keyed && cur_valid && cmp.key_eq && !hit_ff) begin
               hit_in     = 1'b1;
               hit_idx_in = cnt_ff;
               hop_in     = rd_entry.mac;
            end
            if (req_ff.op == rnhc_pkg::OP_RECORD) begin
               if (!cur_valid && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = cnt_ff;
               end
               if (cur_valid && (!old_have_ff || cmp.ref_lt)) begin
                  old_have_in = 1'b1;
                  old_time_in = rd_entry.stamp;
                  old_idx_in  = cnt_ff;
               end
            end
            if (req_ff.op == rnhc_pkg::OP_PRUNE) begin
               cmd.clr_en = cur_valid && !cmp.ref_lt && cmp.over_ttl;
            end
            if (cnt_ff == LAST) begin
               state_in = (req_ff.op == rnhc_pkg::OP_RECORD) ? ST_WRITE : ST_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_WRITE: begin
            cmd.wr_en = 1'b1;
            cmd.idx   = hit_ff ? hit_idx_ff : (free_ff ? free_idx_ff : old_idx_ff);
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      req_ff      <= req_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      hop_ff      <= hop_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      old_have_ff <= old_have_in;
      old_time_ff <= old_time_in;
      old_idx_ff  <= old_idx_in;
   end

   // read one entry ahead of the evaluated one
   assign rd_addr = (state_ff == ST_SCAN && cnt_ff != LAST) ? cnt_ff + 1'b1 : '0;

   assign cur_req      = req_ff;
   assign oldest       = old_time_ff;
   assign res.found    = hit_ff;
   assign res.next_hop = (req_ff.op == rnhc_pkg::OP_LOOKUP && hit_ff) ? hop_ff : 48'd0;

   a_write_only_record: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WRITE |-> req_ff.op == rnhc_pkg::OP_RECORD)
      else $error("entry write outside a record");

   a_one_store_op: assert property (@(posedge clock) disable iff (reset)
      !(cmd.wr_en && cmd.clr_en))
      else $error("store write and clear together");

   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && cnt_ff == LAST) |=> (state_ff == ST_WRITE || state_ff == ST_DONE))
      else $error("scan ran past last entry");

   a_found_keyed: assert property (@(posedge clock) disable iff (reset)
      (done && res.found) |->
         (req_ff.op == rnhc_pkg::OP_RECORD || req_ff.op == rnhc_pkg::OP_LOOKUP))
      else $error("found raised for an unkeyed op");

   a_hop_lookup_only: assert property (@(posedge clock) disable iff (reset)
      (done && req_ff.op != rnhc_pkg::OP_LOOKUP) |-> res.next_hop == 48'd0)
      else $error("next hop driven outside a lookup");

endmodule

[src/route_next_hop_cache_top.sv]
// Channel  Direction  Handshake            Beat
// req      in         req_valid/req_stall  rnhc_pkg::req_type (op, key, mac, time)
// rsp      out        rsp_valid/rsp_stall  rnhc_pkg::rsp_type (found, next_hop)
// csr      in         csr_write_enable     ttl_ms, 32 bit, no read-back
//
// Lookup and prune scan every entry between accept and result; record then adds a write-back
// state; an unused op code skips the scan and goes straight to the result.
// The scan takes one entry per cycle through the store's single registered read port
// into the shared compare unit.
// Reset clears all valid bits at once; no clearing pass is needed.
// A new beat is taken once the previous result sits in the output register, even while
// rsp_stall holds it; the next result then waits for that register to drain.
module route_next_hop_cache_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rnhc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rnhc_pkg::rsp_type rsp_data,
   input  logic              csr_write_enable,
   input  logic [31:0]       csr_write_data
);

   logic [31:0]                      ttl_ff, ttl_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   rnhc_pkg::rsp_type                rsp_data_ff, rsp_data_in;
   logic                             rsp_free;
   logic                             done;
   rnhc_pkg::rsp_type                res;
   rnhc_pkg::store_cmd_type          cmd;
   logic [rnhc_pkg::IDX_W-1:0]       rd_addr;
   rnhc_pkg::entry_type              rd_entry;
   logic [rnhc_pkg::ENTRIES-1:0]     valid;
   rnhc_pkg::cmp_type                cmp;
   rnhc_pkg::req_type                cur_req;
   logic [31:0]                      oldest;

   // take the TTL whenever written; writes must come only while idle, which the block does not enforce
   assign ttl_in = csr_write_enable ? csr_write_data : ttl_ff;

   // output register: free when empty or being drained this cycle
   assign rsp_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = done ? 1'b1 : (rsp_valid_ff && rsp_stall);
   assign rsp_data_in  = done ? res : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ttl_ff       <= rnhc_pkg::TTL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         ttl_ff       <= ttl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // entry store: valid flags in flops, entry fields in a registered-read array
   rnhc_store u_store (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry),
      .valid    (valid)
   );

   // shared compare unit: key match, age ordering, TTL test
   rnhc_unit u_unit (
      .entry  (rd_entry),
      .req    (cur_req),
      .oldest (oldest),
      .ttl    (ttl_ff),
      .cmp    (cmp)
   );

   // sequencer: accept, scan every entry (known ops), write back (record only), hand over the result
   rnhc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .rsp_free  (rsp_free),
      .valid     (valid),
      .rd_entry  (rd_entry),
      .cmp       (cmp),
      .cur_req   (cur_req),
      .oldest    (oldest),
      .rd_addr   (rd_addr),
      .cmd       (cmd),
      .done      (done),
      .res       (res)
   );

endmodule
